@@ src/ers_pkg.sv @@
`timescale 1ns / 1ps
package ers_pkg;

  typedef enum logic [0:0] {
    FUNC_SUBMIT   = 1'b0,
    FUNC_COMPLETE = 1'b1
  } func_t;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_QUEUED    = 3'd1,
    ST_REJECTED  = 3'd2,
    ST_IDLE_NONE = 3'd3,
    ST_CPL_IDLE  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_INS_SHIFT,
    BK_INS_WRITE,
    BK_DEL_SHIFT,
    BK_DEL_READ,
    BK_DEL_WAIT,
    BK_REPORT
  } back_state_t;

endpackage

@@ src/ers_front.sv @@
`timescale 1ns / 1ps
// Command front end: capture items into a small queue for the back end.
module ers_front #(
  parameter int SECTOR_BITS = 32,
  parameter int TAG_BITS    = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   func,
  input  logic [SECTOR_BITS-1:0] sector_address,
  input  logic [TAG_BITS-1:0]    request_tag,
  output logic                   busy,
  output logic                   q_valid,
  output logic                   q_func,
  output logic [SECTOR_BITS-1:0] q_sector,
  output logic [TAG_BITS-1:0]    q_tag,
  input  logic                   q_pop
);

  // Two-entry queue; busy while it holds an item.
  logic [1:0]                   qf;
  logic [SECTOR_BITS-1:0]       qs [2];
  logic [TAG_BITS-1:0]          qt [2];
  logic [1:0]                   count;
  logic                         rd;
  logic                         wr;

  assign wr      = start && !busy;
  assign q_valid = (count != 2'd0);
  assign q_func  = qf[rd];
  assign q_sector = qs[rd];
  assign q_tag   = qt[rd];
  // Combinational; the top level holds off new items until the result.
  assign busy    = (count != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= 2'd0;
      rd       <= 1'b0;
    end else begin
      if (wr) begin
        qf[rd ^ count[0]] <= func;
        qs[rd ^ count[0]] <= sector_address;
        qt[rd ^ count[0]] <= request_tag;
      end
      if (q_pop) begin
        rd       <= ~rd;
      end
      count <= count + {1'b0, wr} - {1'b0, q_pop};
    end
  end

endmodule

@@ src/ers_back.sv @@
`timescale 1ns / 1ps
// Back end: sorted store walked entry by entry; one item is processed at a time.
module ers_back #(
  parameter int QUEUE_DEPTH = 16,
  parameter int SECTOR_BITS = 32,
  parameter int TAG_BITS    = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  logic                   q_func,
  input  logic [SECTOR_BITS-1:0] q_sector,
  input  logic [TAG_BITS-1:0]    q_tag,
  output logic                   q_pop,
  output logic                   done,
  output logic                   strobe,
  output logic [2:0]             status,
  output logic [TAG_BITS-1:0]    grant_tag,
  output logic [SECTOR_BITS-1:0] grant_sector
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [SECTOR_BITS-1:0] mem_s [QUEUE_DEPTH];
  logic [TAG_BITS-1:0]    mem_t [QUEUE_DEPTH];

  ers_pkg::back_state_t state, state_next;

  logic [CW-1:0]          count;
  logic [IW-1:0]          act;
  logic                   act_valid;
  logic                   up;
  logic                   func_r;
  logic [SECTOR_BITS-1:0] sec_r;
  logic [TAG_BITS-1:0]    tag_r;
  logic [CW-1:0]          ptr;
  logic [SECTOR_BITS-1:0] rd_s;
  logic [TAG_BITS-1:0]    rd_t;
  logic [2:0]             st_r;
  logic                   gr_from_mem;
  logic [IW-1:0]          rd_addr;
  logic                   wen;
  logic [IW-1:0]          wa;
  logic [SECTOR_BITS-1:0] wd_s;
  logic [TAG_BITS-1:0]    wd_t;
  logic [CW-1:0]          act_ext;

  assign act_ext = CW'(act);
  assign q_pop   = (state == ers_pkg::BK_IDLE) && q_valid;

  // Memory: one write, one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wen) begin
      mem_s[wa] <= wd_s;
      mem_t[wa] <= wd_t;
    end
    rd_s <= mem_s[rd_addr];
    rd_t <= mem_t[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ers_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Read address issued this cycle; data lands in rd_s/rd_t next cycle.
  always_comb begin
    rd_addr = ptr[IW-1:0];
    wen = 1'b0;
    wa = ptr[IW-1:0];
    wd_s = rd_s;
    wd_t = rd_t;
    state_next = state;
    case (state)
      ers_pkg::BK_IDLE: begin
        if (q_valid) state_next = ers_pkg::BK_SEARCH;
      end
      ers_pkg::BK_SEARCH: begin
        state_next = ers_pkg::BK_REPORT;
        if (func_r == ers_pkg::FUNC_SUBMIT) begin
          if (count < CW'(QUEUE_DEPTH)) state_next = ers_pkg::BK_INS_SHIFT;
        end else if (act_valid && count != '0 && act_ext < count) begin
          state_next = ers_pkg::BK_DEL_SHIFT;
        end
      end
      ers_pkg::BK_INS_SHIFT: begin
        // ptr walks down from count; rd_s holds entry ptr-1 once primed.
        rd_addr = IW'(ptr - CW'(1));
        state_next = ers_pkg::BK_INS_WRITE;
      end
      ers_pkg::BK_INS_WRITE: begin
        wa = ptr[IW-1:0];
        wen = 1'b1;
        if (ptr != '0 && rd_s > sec_r) begin
          wd_s = rd_s;
          wd_t = rd_t;
          state_next = ers_pkg::BK_INS_SHIFT;
        end else begin
          wd_s = sec_r;
          wd_t = tag_r;
          state_next = ers_pkg::BK_REPORT;
        end
      end
      ers_pkg::BK_DEL_SHIFT: begin
        rd_addr = IW'(ptr + CW'(1));
        if (ptr + CW'(1) >= count) begin
          state_next = ers_pkg::BK_DEL_READ;
        end else begin
          state_next = ers_pkg::BK_DEL_WAIT;
        end
      end
      ers_pkg::BK_DEL_WAIT: begin
        wen = 1'b1;
        wa = ptr[IW-1:0];
        state_next = ers_pkg::BK_DEL_SHIFT;
      end
      ers_pkg::BK_DEL_READ: begin
        rd_addr = act;
        state_next = ers_pkg::BK_REPORT;
      end
      ers_pkg::BK_REPORT: begin
        state_next = ers_pkg::BK_IDLE;
      end
      default: state_next = ers_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      act       <= '0;
      act_valid <= 1'b0;
      up        <= 1'b1;
      strobe    <= 1'b0;
      done      <= 1'b0;
      gr_from_mem <= 1'b0;
    end else begin
      strobe <= 1'b0;
      done   <= 1'b0;
      case (state)
        ers_pkg::BK_IDLE: begin
          func_r <= q_func;
          sec_r  <= q_sector;
          tag_r  <= q_tag;
        end
        ers_pkg::BK_SEARCH: begin
          gr_from_mem <= 1'b0;
          if (func_r == ers_pkg::FUNC_SUBMIT) begin
            if (count >= CW'(QUEUE_DEPTH)) begin
              st_r <= ers_pkg::ST_REJECTED;
            end else begin
              ptr <= count;
            end
          end else if (act_valid && count != '0 && act_ext < count) begin
            // Apply reversal rule, then shift out the active entry.
            if (up && act_ext == count - CW'(1)) begin
              up <= 1'b0;
            end else if (!up && act == '0) begin
              up <= 1'b1;
            end
            ptr <= act_ext;
          end else begin
            st_r <= ers_pkg::ST_CPL_IDLE;
          end
        end
        ers_pkg::BK_INS_WRITE: begin
          if (ptr != '0 && rd_s > sec_r) begin
            ptr <= ptr - CW'(1);
          end else begin
            count <= count + CW'(1);
            if (count == '0) begin
              act       <= ptr[IW-1:0];
              act_valid <= 1'b1;
              st_r      <= ers_pkg::ST_GRANTED;
              grant_tag    <= tag_r;
              grant_sector <= sec_r;
            end else begin
              if (act_valid && act_ext >= ptr) act <= act + IW'(1);
              st_r <= ers_pkg::ST_QUEUED;
            end
          end
        end
        ers_pkg::BK_DEL_WAIT: begin
          ptr <= ptr + CW'(1);
        end
        ers_pkg::BK_DEL_SHIFT: begin
          if (ptr + CW'(1) >= count) begin
            count <= count - CW'(1);
            if (up) begin
              if (act_ext + CW'(1) < count) begin
                st_r <= ers_pkg::ST_GRANTED;
                gr_from_mem <= 1'b1;
              end else begin
                act_valid <= 1'b0;
                act <= '0;
                st_r <= ers_pkg::ST_IDLE_NONE;
              end
            end else if (act != '0) begin
              act <= act - IW'(1);
              st_r <= ers_pkg::ST_GRANTED;
              gr_from_mem <= 1'b1;
            end else begin
              act_valid <= 1'b0;
              st_r <= ers_pkg::ST_IDLE_NONE;
            end
          end
        end
        ers_pkg::BK_REPORT: begin
          strobe <= 1'b1;
          done   <= 1'b1;
          if (gr_from_mem) begin
            grant_tag    <= rd_t;
            grant_sector <= rd_s;
          end else if (st_r != ers_pkg::ST_GRANTED) begin
            grant_tag    <= '0;
            grant_sector <= '0;
          end
          status <= st_r;
        end
        default: ;
      endcase
    end
  end

endmodule

@@ src/elevator_request_scheduler_unit.sv @@
`timescale 1ns / 1ps
// LOOK elevator scheduler for one disk's block requests.
// Command channel: drive func, sector_address and request_tag with start high;
// the item is taken on a rising edge where busy is low. func 0 submits a
// request into a store kept sorted by sector (ties go after equal sectors);
// func 1 retires the active request and grants its neighbour in the sweep
// direction, reversing at either end of the store.
// Result channel: strobe is high for exactly one cycle with status,
// grant_tag and grant_sector; grant fields are zero unless status is granted.
// The receiver cannot stall, so results are never held.
// Processing: a submit walks the store from the top down, a shift and a write
// state per entry moved, until the new item's place is found; a complete
// shifts the entries above the active one down; a reject or a complete while
// idle goes straight to the report. busy stays high until the strobe, so the
// next item is taken only after the result. One item is processed at a time,
// set by the busy hold-off in the top level and the back end's idle state.
// Reset (rst, synchronous): store empty, no active request, sweep up.
module elevator_request_scheduler_unit #(
  parameter int QUEUE_DEPTH = 16,
  parameter int SECTOR_BITS = 32,
  parameter int TAG_BITS    = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic                   func,
  input  logic [SECTOR_BITS-1:0] sector_address,
  input  logic [TAG_BITS-1:0]    request_tag,
  output logic                   strobe,
  output logic [2:0]             status,
  output logic [TAG_BITS-1:0]    grant_tag,
  output logic [SECTOR_BITS-1:0] grant_sector
);

  logic                   q_valid;
  logic                   q_func;
  logic [SECTOR_BITS-1:0] q_sector;
  logic [TAG_BITS-1:0]    q_tag;
  logic                   q_pop;
  logic                   done;
  logic                   front_busy;
  logic                   hold;

  // Hold busy from accept until the result strobe clears the item.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else if (start && !busy) begin
      hold <= 1'b1;
    end else if (done) begin
      hold <= 1'b0;
    end
  end

  assign busy = front_busy || hold;

  ers_front #(.SECTOR_BITS(SECTOR_BITS), .TAG_BITS(TAG_BITS)) u_front (
    .clk, .rst,
    .start(start && !hold),
    .func, .sector_address, .request_tag,
    .busy(front_busy),
    .q_valid, .q_func, .q_sector, .q_tag, .q_pop
  );

  ers_back #(
    .QUEUE_DEPTH(QUEUE_DEPTH), .SECTOR_BITS(SECTOR_BITS), .TAG_BITS(TAG_BITS)
  ) u_back (
    .clk, .rst,
    .q_valid, .q_func, .q_sector, .q_tag, .q_pop,
    .done, .strobe, .status, .grant_tag, .grant_sector
  );

endmodule
